// ----- hw/rtl/dosdt_pkg.sv -----
// dosdt_pkg: shared types, constants and calendar tables for the dos date-time converter
`timescale 1ns / 1ps
package dosdt_pkg;

    // field masks of the dos word
    localparam logic [4:0] SecMask  = 5'h1f;
    localparam logic [5:0] MinMask  = 6'h3f;
    localparam logic [4:0] HourMask = 5'h1f;
    localparam logic [4:0] DayMask  = 5'h1f;
    localparam logic [3:0] MonMask  = 4'h0f;
    localparam int unsigned YearBase = 80;   // dos year 0 is 1900 + 80

    // year offsets are counted from 1600 so that the 400-year cycle starts at zero
    localparam int unsigned EraYear   = 1600;
    localparam logic [8:0]  KBase     = 9'(1900 + YearBase - 1 - EraYear);
    // days from 1600-03-01 count origin to 1970-01-01, less the 1600 head start
    localparam logic [17:0] DayBias   = 18'd135080;
    localparam logic [32:0] SecPerDay = 33'd86400;
    localparam logic [16:0] SecPerHr  = 17'd3600;
    localparam logic [16:0] SecPerMin = 17'd60;
    // floor(k / 100) for k below 512 is (k * Div100Mul) >> Div100Sh
    localparam logic [5:0]  Div100Mul = 6'd41;
    localparam int unsigned Div100Sh  = 12;
    localparam logic [8:0]  Year400   = 9'd400;

    typedef struct packed {
        logic [1:0] adj;   // year shift relative to year-1979
        logic [3:0] mp;    // month index with march as zero
    } t_mon_map;

    typedef struct packed {
        logic       valid;
        logic [8:0] k;       // march-based year minus 1600
        logic [8:0] cum;     // days before the month in the march-based year
        logic [4:0] day;
        logic [4:0] hour;
        logic [5:0] minute;
        logic [4:0] sec2;
    } t_s1;

    typedef struct packed {
        logic        valid;
        logic [15:0] days;   // days since the epoch
        logic [16:0] tod;    // seconds within the day, may exceed one day
    } t_s2;

    typedef struct packed {
        logic        valid;
        logic [32:0] prod;
        logic [16:0] tod;
    } t_s3;

    // month field to march-based month and year shift, with wrap of out-of-range months
    function automatic t_mon_map month_map(input logic [3:0] mon);
        t_mon_map m;
        case (mon) inside
            4'd0:           begin m.adj = 2'd0; m.mp = 4'd9;  end
            4'd1:           begin m.adj = 2'd0; m.mp = 4'd10; end
            4'd2:           begin m.adj = 2'd0; m.mp = 4'd11; end
            [4'd3:4'd12]:   begin m.adj = 2'd1; m.mp = mon - 4'd3; end
            4'd13:          begin m.adj = 2'd1; m.mp = 4'd10; end
            4'd14:          begin m.adj = 2'd1; m.mp = 4'd11; end
            default:        begin m.adj = 2'd2; m.mp = 4'd0;  end
        endcase
        return m;
    endfunction

    // days before month mp in a year that starts in march
    function automatic logic [8:0] cum_days(input logic [3:0] mp);
        logic [8:0] c;
        case (mp)
            4'd0:    c = 9'd0;
            4'd1:    c = 9'd31;
            4'd2:    c = 9'd61;
            4'd3:    c = 9'd92;
            4'd4:    c = 9'd122;
            4'd5:    c = 9'd153;
            4'd6:    c = 9'd184;
            4'd7:    c = 9'd214;
            4'd8:    c = 9'd245;
            4'd9:    c = 9'd275;
            4'd10:   c = 9'd306;
            4'd11:   c = 9'd337;
            default: c = 9'd0;
        endcase
        return c;
    endfunction

endpackage

// ----- hw/rtl/dosdt_unpack.sv -----
// dosdt_unpack: first stage, splits the dos word and maps the month
`timescale 1ns / 1ps
module dosdt_unpack
    import dosdt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic [31:0] i_word,
    output t_s1         o_s1
);

    t_s1      r_s1;
    t_s1      n_s1;
    t_mon_map w_map;

    always_comb begin
        w_map        = month_map(i_word[24:21] & MonMask);
        n_s1.valid   = i_valid;
        n_s1.k       = 9'(i_word[31:25]) + KBase + 9'(w_map.adj);
        n_s1.cum     = cum_days(w_map.mp);
        n_s1.day     = i_word[20:16] & DayMask;
        n_s1.hour    = i_word[15:11] & HourMask;
        n_s1.minute  = i_word[10:5] & MinMask;
        n_s1.sec2    = i_word[4:0] & SecMask;
    end

    // only the valid bit is reset, the data fields just follow
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1.valid <= 1'b0;
        end else begin
            r_s1.valid <= n_s1.valid;
        end
        r_s1.k      <= n_s1.k;
        r_s1.cum    <= n_s1.cum;
        r_s1.day    <= n_s1.day;
        r_s1.hour   <= n_s1.hour;
        r_s1.minute <= n_s1.minute;
        r_s1.sec2   <= n_s1.sec2;
    end

    assign o_s1 = r_s1;

endmodule

// ----- hw/rtl/dosdt_days.sv -----
// dosdt_days: second stage, day count since the epoch and seconds of the day
`timescale 1ns / 1ps
module dosdt_days
    import dosdt_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_s1  i_s1,
    output t_s2  o_s2
);

    t_s2         r_s2;
    t_s2         n_s2;
    logic [17:0] w_k365;
    logic [14:0] w_k41;
    logic [2:0]  w_q100;
    logic [17:0] w_pos;
    logic [17:0] w_neg;
    logic [17:0] w_days;

    always_comb begin
        w_k365 = 18'(i_s1.k) * 18'd365;
        w_k41  = 15'(i_s1.k) * 15'(Div100Mul);
        w_q100 = 3'(w_k41 >> Div100Sh);
        // leap days: k/4 - k/100 + k/400, and k stays below 800
        w_pos  = w_k365 + 18'(i_s1.k >> 2) + 18'(i_s1.k >= Year400)
               + 18'(i_s1.cum) + 18'(i_s1.day);
        w_neg  = 18'(w_q100) + 18'd1 + DayBias;
        w_days = w_pos - w_neg;

        n_s2.valid = i_s1.valid;
        n_s2.days  = w_days[15:0];
        n_s2.tod   = 17'(i_s1.hour) * SecPerHr + 17'(i_s1.minute) * SecPerMin
                   + {11'd0, i_s1.sec2, 1'b0};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2.valid <= 1'b0;
        end else begin
            r_s2.valid <= n_s2.valid;
        end
        r_s2.days <= n_s2.days;
        r_s2.tod  <= n_s2.tod;
    end

    assign o_s2 = r_s2;

endmodule

// ----- hw/rtl/dosdt_scale.sv -----
// dosdt_scale: third and fourth stages, days to seconds and final sum
`timescale 1ns / 1ps
module dosdt_scale
    import dosdt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_s2         i_s2,
    output logic        o_valid,
    output logic [32:0] o_seconds
);

    t_s3         r_s3;
    t_s3         n_s3;
    logic        r_valid;
    logic [32:0] r_seconds;
    logic [32:0] n_seconds;

    always_comb begin
        n_s3.valid = i_s2.valid;
        n_s3.prod  = 33'(i_s2.days) * SecPerDay;
        n_s3.tod   = i_s2.tod;
        n_seconds  = r_s3.prod + 33'(r_s3.tod);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3.valid <= 1'b0;
            r_valid    <= 1'b0;
        end else begin
            r_s3.valid <= n_s3.valid;
            r_valid    <= r_s3.valid;
        end
        r_s3.prod <= n_s3.prod;
        r_s3.tod  <= n_s3.tod;
        r_seconds <= n_seconds;
    end

    assign o_valid   = r_valid;
    assign o_seconds = r_seconds;

endmodule

// ----- hw/rtl/dos_datetime_to_unix_seconds.sv -----
// dos_datetime_to_unix_seconds: top level, dos date-time word to unix seconds
// throughput: one word per cycle, busy never rises, four stages are always moving
// stage cut: unpack and month map, day count, multiply by seconds per day, final add
// reset: synchronous active low, clears the stage valid bits only
// the receiver cannot stall, so nothing holds the pipeline
`timescale 1ns / 1ps
module dos_datetime_to_unix_seconds
    import dosdt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] i_packed_datetime,
    output logic        o_valid,
    output logic [32:0] o_epoch_seconds
);

    t_s1 w_s1;
    t_s2 w_s2;

    assign busy = 1'b0;

    dosdt_unpack u_unpack (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (start & ~busy),
        .i_word  (i_packed_datetime),
        .o_s1    (w_s1)
    );

    dosdt_days u_days (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_s1    (w_s1),
        .o_s2    (w_s2)
    );

    dosdt_scale u_scale (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s2      (w_s2),
        .o_valid   (o_valid),
        .o_seconds (o_epoch_seconds)
    );

    // every accepted word comes out with its strobe once it has passed through the pipeline registers
    a_latency : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##4 o_valid)
        else $error("missing strobe four cycles after accept");

    // no strobe without an accepted word at the pipeline input, matched by the same depth
    a_no_extra : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && $past(i_rst_n, 1) && $past(i_rst_n, 2) && $past(i_rst_n, 3)
         && $past(i_rst_n, 4)) |-> $past(start, 4))
        else $error("strobe without accepted word");

    // earliest reachable date is 1979-11-30, so the day count never wraps
    a_floor : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_epoch_seconds >= 33'd312768000))
        else $error("epoch seconds below earliest date");

    // the day stage result never reaches past 2108
    a_days_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_s2.valid |-> (w_s2.days <= 16'd50830 && w_s2.days >= 16'd3620))
        else $error("day count out of range");

endmodule

// ----- test/dos_datetime_to_unix_seconds_tb.sv -----
// dos_datetime_to_unix_seconds_tb: directed and random regression of the dos word to unix seconds converter
`timescale 1ns / 1ps
module dos_datetime_to_unix_seconds_tb;

    localparam int unsigned RandWords  = 1750;
    localparam int unsigned StallLimit = 2000;
    localparam int unsigned TailCycles = 12;
    localparam int unsigned MaxPrints  = 30;

    typedef struct {
        logic [31:0] word;
        bit          pinned;     // expected value typed in by hand
        logic [32:0] pinned_secs;
    } t_dir_row;

    typedef struct {
        logic [31:0] word;
        logic [32:0] secs;
    } t_due;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [31:0] i_packed_datetime;
    logic        o_valid;
    logic [32:0] o_epoch_seconds;

    // side info that travels with the word on the input
    bit          row_pinned;
    logic [32:0] row_pinned_secs;

    t_due        epoch_due[$];
    t_dir_row    dir_rows[$];
    int unsigned mismatch_cnt;
    int unsigned words_in;
    int unsigned results_out;
    int unsigned idle_cycles;

    dos_datetime_to_unix_seconds u_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_packed_datetime (i_packed_datetime),
        .o_valid           (o_valid),
        .o_epoch_seconds   (o_epoch_seconds)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // day count on the proleptic gregorian calendar, out-of-range fields carry over
    function automatic logic [32:0] dos_to_epoch(input logic [31:0] w);
        longint s, mn, hr, dd, mo, yr, yshift, cyc400, yin_cyc, mar_mon, day_in_yr;
        longint day_in_cyc, day_num, secs;
        s  = w[4:0];
        mn = w[10:5];
        hr = w[15:11];
        dd = w[20:16];
        mo = w[24:21];
        yr = w[31:25];
        s  = s * 2;
        yr = yr + 1980;
        mo = mo - 1;
        if (mo < 0) begin
            mo = mo + 12;
            yr = yr - 1;
        end else if (mo >= 12) begin
            mo = mo - 12;
            yr = yr + 1;
        end
        mo = mo + 1;
        // years start in march so that the leap day falls at the end
        yshift     = (mo <= 2) ? yr - 1 : yr;
        cyc400     = yshift / 400;
        yin_cyc    = yshift - cyc400 * 400;
        mar_mon    = (mo > 2) ? mo - 3 : mo + 9;
        day_in_yr  = (153 * mar_mon + 2) / 5 + dd - 1;
        day_in_cyc = yin_cyc * 365 + yin_cyc / 4 - yin_cyc / 100 + day_in_yr;
        day_num    = cyc400 * 146097 + day_in_cyc - 719468;
        secs       = day_num * 86400 + hr * 3600 + mn * 60 + s;
        return secs[32:0];
    endfunction

    function automatic logic [31:0] pack_dos(input int unsigned yoff, input int unsigned mon,
                                             input int unsigned day, input int unsigned hr,
                                             input int unsigned mn, input int unsigned s2);
        return {yoff[6:0], mon[3:0], day[4:0], hr[4:0], mn[5:0], s2[4:0]};
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] w,
                                   input logic [32:0] got, input logic [32:0] want);
        if (mismatch_cnt < MaxPrints)
            $display("[%0t] mismatch %s: word %h got %0d want %0d", $realtime, what, w, got, want);
        mismatch_cnt++;
    endtask

    // check results and log accepted words in one place so order within the edge is fixed
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid) begin
                results_out++;
                if (epoch_due.size() == 0) begin
                    report_mismatch("unexpected result", 32'h0, o_epoch_seconds, 33'h0);
                end else begin
                    if (o_epoch_seconds !== epoch_due[0].secs)
                        report_mismatch("epoch_seconds", epoch_due[0].word, o_epoch_seconds,
                                        epoch_due[0].secs);
                    void'(epoch_due.pop_front());
                end
            end
            if (start && !busy) begin
                words_in++;
                epoch_due.push_back('{word: i_packed_datetime,
                                      secs: row_pinned ? row_pinned_secs
                                                       : dos_to_epoch(i_packed_datetime)});
            end
        end
    end

    // watchdog on cycles where no word goes in and no result comes out
    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= StallLimit) begin
            $display("[%0t] watchdog: no progress for %0d cycles", $realtime, StallLimit);
            $display("dos_datetime_to_unix_seconds regression: fail");
            $finish;
        end
    end

    task automatic issue_word(input logic [31:0] w, input bit pinned,
                              input logic [32:0] pinned_secs, input int unsigned gap);
        repeat (gap) begin
            @(negedge i_clk);
            start <= 1'b0;
        end
        @(negedge i_clk);
        start             <= 1'b1;
        i_packed_datetime <= w;
        row_pinned        <= pinned;
        row_pinned_secs   <= pinned_secs;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        start <= 1'b0;
        while (epoch_due.size() != 0) @(posedge i_clk);
    endtask

    function automatic int unsigned pick_gap(input bit burst);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (burst || r < 65) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [31:0] rand_word();
        int unsigned mode;
        mode = $urandom_range(0, 9);
        // mostly calendar-shaped words, the rest anything the 32 bits allow
        if (mode < 6)
            return pack_dos($urandom_range(0, 127), $urandom_range(1, 12), $urandom_range(1, 31),
                            $urandom_range(0, 23), $urandom_range(0, 59), $urandom_range(0, 29));
        if (mode < 8)
            return {7'($urandom_range(0, 127)), 4'($urandom_range(0, 15)),
                    5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)),
                    6'($urandom_range(0, 63)), 5'($urandom_range(0, 31))};
        return $urandom;
    endfunction

    initial begin
        int unsigned burst_left;
        int unsigned drain_at;
        mismatch_cnt      = 0;
        words_in          = 0;
        results_out       = 0;
        idle_cycles       = 0;
        burst_left        = 0;
        i_rst_n           = 1'b0;
        start             = 1'b0;
        i_packed_datetime = 32'h0;
        row_pinned        = 1'b0;
        row_pinned_secs   = 33'h0;

        // lowest word lands on 1979-11-30, then well-known epochs, then field wrap and overflow words
        dir_rows.push_back('{32'h0000_0000, 1'b1, 33'd312768000});
        dir_rows.push_back('{pack_dos(0, 1, 1, 0, 0, 0), 1'b1, 33'd315532800});
        dir_rows.push_back('{pack_dos(20, 1, 1, 0, 0, 0), 1'b1, 33'd946684800});
        dir_rows.push_back('{32'hffff_ffff, 1'b0, 33'h0});
        dir_rows.push_back('{pack_dos(5, 0, 15, 12, 30, 15), 1'b0, 33'h0});
        dir_rows.push_back('{pack_dos(7, 13, 10, 1, 2, 3), 1'b0, 33'h0});
        dir_rows.push_back('{pack_dos(8, 14, 31, 4, 5, 6), 1'b0, 33'h0});
        dir_rows.push_back('{pack_dos(9, 15, 31, 7, 8, 9), 1'b0, 33'h0});
        dir_rows.push_back('{pack_dos(10, 3, 0, 0, 0, 0), 1'b0, 33'h0});
        dir_rows.push_back('{pack_dos(21, 2, 31, 10, 20, 5), 1'b0, 33'h0});
        dir_rows.push_back('{pack_dos(44, 6, 15, 31, 63, 31), 1'b0, 33'h0});
        dir_rows.push_back('{pack_dos(44, 6, 15, 24, 60, 30), 1'b0, 33'h0});
        dir_rows.push_back('{pack_dos(20, 2, 29, 23, 59, 29), 1'b0, 33'h0});
        dir_rows.push_back('{pack_dos(120, 2, 29, 0, 0, 0), 1'b0, 33'h0});
        dir_rows.push_back('{pack_dos(124, 2, 29, 12, 0, 0), 1'b0, 33'h0});
        dir_rows.push_back('{pack_dos(127, 12, 31, 23, 59, 29), 1'b0, 33'h0});
        dir_rows.push_back('{pack_dos(127, 0, 0, 0, 0, 0), 1'b0, 33'h0});
        dir_rows.push_back('{pack_dos(0, 0, 31, 31, 63, 31), 1'b0, 33'h0});
        dir_rows.push_back('{32'h5555_5555, 1'b0, 33'h0});
        dir_rows.push_back('{32'haaaa_aaaa, 1'b0, 33'h0});

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i])
            issue_word(dir_rows[i].word, dir_rows[i].pinned, dir_rows[i].pinned_secs,
                       (i % 3 == 2) ? 1 : 0);
        drain_results();

        drain_at = $urandom_range(RandWords / 3, 2 * RandWords / 3);
        for (int unsigned n = 0; n < RandWords; n++) begin
            if (burst_left == 0 && $urandom_range(0, 99) < 2)
                burst_left = $urandom_range(20, 60);
            issue_word(rand_word(), 1'b0, 33'h0, pick_gap(burst_left != 0));
            if (burst_left != 0) burst_left--;
            if (n == drain_at) drain_results();
        end
        drain_results();
        repeat (TailCycles) @(posedge i_clk);

        $display("covered %0d words, %0d directed and %0d random, %0d results checked",
                 words_in, dir_rows.size(), RandWords, results_out);
        $display("month and day wrap, field overflow, century leap rules, gaps and bursts");
        if (mismatch_cnt == 0 && epoch_due.size() == 0) begin
            $display("dos_datetime_to_unix_seconds regression: pass");
        end else begin
            $display("%0d mismatches, %0d results missing", mismatch_cnt, epoch_due.size());
            $display("dos_datetime_to_unix_seconds regression: fail");
        end
        $finish;
    end

endmodule
